// ----- hw/rtl/twu_pkg.sv -----
package twu_pkg;

   localparam int BIN_BITS       = 22;
   localparam int PART_BITS      = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_START  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_END    = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOISE_START = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOISE_END   = 4'd3;

   localparam logic [1:0] WIN_ZERO = 2'd0;
   localparam logic [1:0] WIN_ONE  = 2'd1;
   localparam logic [1:0] WIN_RISE = 2'd2;
   localparam logic [1:0] WIN_FALL = 2'd3;

   localparam logic [31:0] SIN_C4 = 32'd172272;
   localparam logic [31:0] SIN_C3 = 32'd5026995;
   localparam logic [31:0] SIN_C2 = 32'd85569306;
   localparam logic [31:0] SIN_C1 = 32'd693598668;
   localparam logic [31:0] SIN_C0 = 32'd1686629713;

   typedef struct packed {
      logic [BIN_BITS-1:0]         bin_index;
      logic signed [PART_BITS-1:0] main_real;
      logic signed [PART_BITS-1:0] main_imag;
      logic signed [PART_BITS-1:0] resid_real;
      logic signed [PART_BITS-1:0] resid_imag;
      logic [PART_BITS-1:0]        noise_power;
   } req_item_type;

   typedef struct packed {
      logic [BIN_BITS-1:0]         out_bin;
      logic signed [PART_BITS-1:0] white_main_real;
      logic signed [PART_BITS-1:0] white_main_imag;
      logic signed [PART_BITS-1:0] white_resid_real;
      logic signed [PART_BITS-1:0] white_resid_imag;
      logic                        bad_noise;
   } rsp_item_type;

   typedef struct packed {
      logic [BIN_BITS-1:0]            bin;
      logic [3:0][PART_BITS-1:0]      parts;
      logic [PART_BITS-1:0]           noise_power;
      logic                           live;
      logic                           bad;
      logic [1:0]                     kind;
      logic [BIN_BITS-1:0]            span;
      logic [BIN_BITS-1:0]            num;
   } cls_item_type;

   typedef struct packed {
      logic empty;
      logic almost_full;
   } queue_status_type;

endpackage

// ----- hw/rtl/twu_queue.sv -----
module twu_queue #(
   parameter int DEPTH = twu_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  twu_pkg::cls_item_type      push_item,
   input  logic                       pop,
   output twu_pkg::cls_item_type      head,
   output twu_pkg::queue_status_type  stat
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] ALMOST   = CNT_BITS'(DEPTH - 1);

   twu_pkg::cls_item_type entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign do_push = push && (count_ff != CNT_BITS'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign stat.empty       = (count_ff == '0);
   assign stat.almost_full = (count_ff >= ALMOST);

endmodule

// ----- hw/rtl/twu_front.sv -----
module twu_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  twu_pkg::req_item_type                 req_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [twu_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [twu_pkg::BIN_BITS-1:0]          csr_data,
   input  twu_pkg::queue_status_type             q_stat,
   output logic                                  push,
   output twu_pkg::cls_item_type                 push_item
);

   localparam int B = twu_pkg::BIN_BITS;

   logic [B-1:0] band_start_ff, band_end_ff, noise_start_ff, noise_end_ff;
   logic         valid_ff, valid_in;
   twu_pkg::cls_item_type item_ff, item_in;

   logic [B-1:0] n_w, span_w;
   logic [B+4:0] t1_w, t2_w, tn_w, mag_w;
   logic         in_band, in_noise, zero_power, accept;

   assign csr_ready = 1'b1;
   assign busy      = q_stat.almost_full;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_start_ff  <= '0;
         band_end_ff    <= '1;
         noise_start_ff <= '0;
         noise_end_ff   <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            twu_pkg::CSR_BAND_START:  band_start_ff  <= csr_data;
            twu_pkg::CSR_BAND_END:    band_end_ff    <= csr_data;
            twu_pkg::CSR_NOISE_START: noise_start_ff <= csr_data;
            twu_pkg::CSR_NOISE_END:   noise_end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_band    = (req_item.bin_index >= band_start_ff) && (req_item.bin_index < band_end_ff);
      in_noise   = (req_item.bin_index >= noise_start_ff) && (req_item.bin_index < noise_end_ff);
      zero_power = (req_item.noise_power == '0);
      n_w        = req_item.bin_index - band_start_ff;
      span_w     = band_end_ff - band_start_ff - 1'b1;
      t1_w       = ({5'b0, n_w} + 1'b1) * 5'd20;
      t2_w       = {5'b0, span_w} * 5'd19;
      tn_w       = {5'b0, n_w} * 5'd20;
      mag_w      = (tn_w >= t2_w) ? (tn_w - t2_w) : (t2_w - tn_w);

      item_in.bin         = req_item.bin_index;
      item_in.parts[0]    = req_item.main_real;
      item_in.parts[1]    = req_item.main_imag;
      item_in.parts[2]    = req_item.resid_real;
      item_in.parts[3]    = req_item.resid_imag;
      item_in.noise_power = req_item.noise_power;
      item_in.live        = in_noise && !zero_power;
      item_in.bad         = in_noise && zero_power;
      item_in.span        = span_w;
      item_in.num         = '0;
      item_in.kind        = twu_pkg::WIN_ZERO;
      if (!in_band) begin
         item_in.kind = twu_pkg::WIN_ZERO;
      end else if (span_w == '0) begin
         item_in.kind = twu_pkg::WIN_ONE;
      end else if (t1_w <= {5'b0, span_w}) begin
         item_in.kind = twu_pkg::WIN_RISE;
         item_in.num  = tn_w[B-1:0];
      end else if (t1_w <= t2_w) begin
         item_in.kind = twu_pkg::WIN_ONE;
      end else if (mag_w >= {5'b0, span_w}) begin
         item_in.kind = twu_pkg::WIN_ZERO;
      end else begin
         item_in.kind = twu_pkg::WIN_FALL;
         item_in.num  = mag_w[B-1:0];
      end
      valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push      = valid_ff;
   assign push_item = item_ff;

endmodule

// ----- hw/rtl/twu_back.sv -----
module twu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  twu_pkg::cls_item_type      q_head,
   input  twu_pkg::queue_status_type  q_stat,
   output logic                       pop,
   output logic                       rsp_strobe,
   output twu_pkg::rsp_item_type      rsp_item
);

   localparam int B          = twu_pkg::BIN_BITS;
   localparam int WIN_STEPS  = 30;
   localparam int SQRT_STEPS = 28;
   localparam int POLY0      = WIN_STEPS;
   localparam int POLY_W     = POLY0 + 6;
   localparam int DIV0       = POLY_W + 1;
   localparam int DIV_STEPS  = 56;
   localparam int MUL0       = DIV0 + DIV_STEPS;
   localparam int SUM0       = MUL0 + 1;
   localparam int SAT0       = SUM0 + 1;
   localparam int NST        = SAT0 + 1;

   typedef struct packed {
      logic                 vld;
      logic [B-1:0]         bin;
      logic                 live;
      logic                 bad;
      logic [1:0]           kind;
      logic [B-1:0]         dv;
      logic [B-1:0]         wrem;
      logic [29:0]          wq;
      logic [55:0]          srad;
      logic [31:0]          srem;
      logic [27:0]          sroot;
      logic [30:0]          x;
      logic [30:0]          x2;
      logic [31:0]          pw;
      logic [16:0]          w;
      logic [3:0]           neg;
      logic [3:0][27:0]     qrem;
      logic [3:0][55:0]     qsh;
      logic [3:0][38:0]     ph;
      logic [3:0][38:0]     pl;
      logic [3:0][44:0]     m;
      logic [3:0][31:0]     res;
   } back_stage_type;

   function automatic back_stage_type advance(input back_stage_type s, input int k);
      back_stage_type o;
      logic [31:0] sr;
      logic [31:0] st;
      logic [B:0]  wr;
      logic [28:0] qr;
      logic [63:0] prod;
      logic [30:0] xv;
      logic [60:0] msum;
      logic [44:0] mc;
      logic [31:0] coef;
      logic [19:0] wv;
      o = s;
      if (k < WIN_STEPS) begin
         wr = {s.wrem, 1'b0};
         if (wr >= {1'b0, s.dv}) begin
            o.wrem = B'(wr - {1'b0, s.dv});
            o.wq   = {s.wq[28:0], 1'b1};
         end else begin
            o.wrem = wr[B-1:0];
            o.wq   = {s.wq[28:0], 1'b0};
         end
         if (k < SQRT_STEPS) begin
            sr = {s.srem[29:0], s.srad[55:54]};
            st = {2'b00, s.sroot, 2'b01};
            if (sr >= st) begin
               o.srem  = sr - st;
               o.sroot = {s.sroot[26:0], 1'b1};
            end else begin
               o.srem  = sr;
               o.sroot = {s.sroot[26:0], 1'b0};
            end
            o.srad = {s.srad[53:0], 2'b00};
         end
      end else if (k == POLY0) begin
         xv   = (s.kind == twu_pkg::WIN_RISE) ? {1'b0, s.wq}
                                              : 31'(31'h4000_0000 - {1'b0, s.wq});
         prod = 64'(xv) * 64'(xv);
         o.x  = xv;
         o.x2 = 31'(prod >> 30);
      end else if (k == POLY0 + 1) begin
         prod = 64'(s.x2) * 64'(twu_pkg::SIN_C4);
         o.pw = twu_pkg::SIN_C3 - 32'(prod >> 30);
      end else if (k < POLY0 + 5) begin
         coef = (k == POLY0 + 2) ? twu_pkg::SIN_C2 :
                (k == POLY0 + 3) ? twu_pkg::SIN_C1 : twu_pkg::SIN_C0;
         prod = 64'(s.x2) * 64'(s.pw);
         o.pw = coef - 32'(prod >> 30);
      end else if (k == POLY0 + 5) begin
         prod = 64'(s.x) * 64'(s.pw);
         o.pw = 32'(prod >> 30);
      end else if (k == POLY_W) begin
         prod = 64'(s.pw) * 64'(s.pw) + 64'h0000_0800_0000_0000;
         wv   = 20'(prod >> 44);
         case (s.kind)
            twu_pkg::WIN_ZERO: o.w = '0;
            twu_pkg::WIN_ONE:  o.w = 17'h10000;
            default:           o.w = (wv > 20'h10000) ? 17'h10000 : wv[16:0];
         endcase
      end else if (k < MUL0) begin
         for (int i = 0; i < 4; i++) begin
            qr = {s.qrem[i], s.qsh[i][55]};
            if (qr >= {1'b0, s.sroot}) begin
               o.qrem[i] = 28'(qr - {1'b0, s.sroot});
               o.qsh[i]  = {s.qsh[i][54:0], 1'b1};
            end else begin
               o.qrem[i] = qr[27:0];
               o.qsh[i]  = {s.qsh[i][54:0], 1'b0};
            end
         end
      end else if (k == MUL0) begin
         for (int i = 0; i < 4; i++) begin
            o.ph[i] = 39'(s.qsh[i][43:22]) * 39'(s.w);
            o.pl[i] = 39'(s.qsh[i][21:0]) * 39'(s.w);
         end
      end else if (k == SUM0) begin
         for (int i = 0; i < 4; i++) begin
            msum   = {s.ph[i], 22'b0} + 61'(s.pl[i]);
            o.m[i] = msum[60:16];
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (s.neg[i]) begin
               mc = (s.m[i] > 45'h0_8000_0000) ? 45'h0_8000_0000 : s.m[i];
               mc = 45'(45'd0 - mc);
            end else begin
               mc = (s.m[i] > 45'h0_7FFF_FFFF) ? 45'h0_7FFF_FFFF : s.m[i];
            end
            o.res[i] = s.live ? mc[31:0] : 32'd0;
         end
      end
      return o;
   endfunction

   back_stage_type stg [NST+1];
   back_stage_type head_stage;

   assign pop = !q_stat.empty;

   always_comb begin
      head_stage       = '0;
      head_stage.vld   = pop;
      head_stage.bin   = q_head.bin;
      head_stage.live  = q_head.live;
      head_stage.bad   = q_head.bad;
      head_stage.kind  = q_head.kind;
      head_stage.dv    = q_head.span;
      head_stage.wrem  = q_head.num;
      head_stage.srad  = {q_head.noise_power, 24'b0};
      for (int i = 0; i < 4; i++) begin
         head_stage.neg[i] = q_head.parts[i][31];
         head_stage.qsh[i] = {(q_head.parts[i][31] ? 32'(32'd0 - q_head.parts[i])
                                                   : q_head.parts[i]), 24'b0};
      end
   end

   assign stg[0] = head_stage;

   for (genvar k = 0; k < NST; k++) begin : g_stage
      back_stage_type stage_ff, stage_in;

      always_comb begin
         stage_in = advance(stg[k], k);
         if (reset) begin
            stage_in.vld = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         stage_ff <= stage_in;
      end

      assign stg[k+1] = stage_ff;
   end

   assign rsp_strobe                = stg[NST].vld;
   assign rsp_item.out_bin          = stg[NST].bin;
   assign rsp_item.white_main_real  = stg[NST].res[0];
   assign rsp_item.white_main_imag  = stg[NST].res[1];
   assign rsp_item.white_resid_real = stg[NST].res[2];
   assign rsp_item.white_resid_imag = stg[NST].res[3];
   assign rsp_item.bad_noise        = stg[NST].bad;

endmodule

// ----- hw/rtl/tukey_bandpass_whitening_unit.sv -----
// Channel   Ports                               Direction  Handshake
// request   start, busy, req_item               in         start && !busy
// result    rsp_strobe, rsp_item                out        rsp_strobe, one cycle
// csr       csr_valid, csr_ready, csr_index,    in         csr_valid && csr_ready
//           csr_data
//
// One request is taken every cycle while busy is low; each result passes the front
// register and the queue, then 96 back stages (30-step window divider, window
// polynomial, 56-step quotient divider, multiply, sum, saturate). Synchronous
// active-high reset clears the queue and pipeline valids, and sets the csr starts
// to zero and the csr ends to all ones.
// The receiver cannot stall; busy rises once the front queue is almost full.
module tukey_bandpass_whitening_unit #(
   parameter int FIFO_DEPTH = twu_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  twu_pkg::req_item_type                 req_item,
   output logic                                  rsp_strobe,
   output twu_pkg::rsp_item_type                 rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [twu_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [twu_pkg::BIN_BITS-1:0]          csr_data
);

   twu_pkg::queue_status_type q_stat;
   twu_pkg::cls_item_type     push_item, q_head;
   logic                      push, pop;

   twu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   twu_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   twu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
